>>> design/stree_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// Used by the front, back and top-level modules.
package stree_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;
  localparam int CFG_W = 11;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic clearing;
    logic done;
  } back_status_t;

endpackage

>>> design/stree_fifo.sv
// Two-entry item queue between front and back.
// Depends on nothing but its width parameter.
module stree_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/stree_front.sv
// Front end: accepts items, clips query ranges, drops out-of-range sets and
// turns indices into leaf node addresses. Uses stree_pkg.
module stree_front import stree_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int SW = 11,
  parameter int CW = 12,
  parameter int W  = 2 + 2 * 12 + 32
) (
  input  logic                    start,
  input  logic                    busy,
  input  logic                    opcode,
  input  logic [IDX_W-1:0]        index_or_left,
  input  logic [IDX_W-1:0]        right_end,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic [SW-1:0]           size_in_use,
  output logic                    push,
  output logic [W-1:0]            wdata
);

  localparam int LW = (CW > IDX_W + 1) ? CW : IDX_W + 1;
  localparam int XW = (LW > SW) ? LW : SW;

  logic [XW-1:0] a_x;
  logic [XW-1:0] b_x;
  logic [XW-1:0] s_x;
  logic [XW-1:0] last_x;
  logic [XW-1:0] bc_x;
  logic [XW-1:0] lo_x;
  logic [XW-1:0] hi_x;
  logic          a_ok;
  kind_t         kind;

  always_comb begin
    a_x    = XW'(index_or_left);
    b_x    = XW'(right_end);
    s_x    = XW'(size_in_use);
    last_x = s_x - XW'(1);
    bc_x   = (b_x > last_x) ? last_x : b_x;
    a_ok   = (a_x < s_x);
    lo_x   = a_x + XW'(MAX_ELEMENTS);
    hi_x   = bc_x + XW'(MAX_ELEMENTS) + XW'(1);
    push   = 1'b0;
    kind   = KIND_EMPTY;
    if (start && !busy) begin
      if (opcode == OP_SET) begin
        push = a_ok;
        kind = KIND_SET;
      end else begin
        push = 1'b1;
        kind = (a_ok && a_x <= bc_x) ? KIND_QUERY : KIND_EMPTY;
      end
    end
    wdata = {kind, lo_x[CW-1:0], hi_x[CW-1:0], new_value};
  end

endmodule

>>> design/stree_back.sv
// Back end: clears the node store after reset, then walks the tree for each
// queued set or non-empty query, one level per cycle. Uses stree_pkg.
module stree_back import stree_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int AW = 11,
  parameter int CW = 12,
  parameter int W  = 2 + 2 * 12 + 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [W-1:0]            qdata,
  input  logic                    qempty,
  output logic                    pop,
  output back_status_t            status,
  output logic signed [SUM_W-1:0] range_sum
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SET   = 4'b0100,
    ST_QUERY = 4'b1000
  } state_t;

  localparam int NODES = 2 * MAX_ELEMENTS;

  logic [SUM_W-1:0] mem [NODES];
  logic [SUM_W-1:0] rd0;
  logic [SUM_W-1:0] rd1;

  state_t           state;
  logic [AW-1:0]    cnt;
  logic [CW-1:0]    l;
  logic [CW-1:0]    r;
  logic [SUM_W-1:0] cur;
  logic [SUM_W-1:0] acc;
  logic             first;
  logic             pend;
  logic             v0;
  logic             v1;
  logic             done;

  kind_t                   q_kind;
  logic [CW-1:0]           q_lo;
  logic [CW-1:0]           q_hi;
  logic signed [VAL_W-1:0] q_val;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic [AW-1:0]    ra0;
  logic [AW-1:0]    ra1;
  logic [CW-1:0]    par;
  logic [CW-1:0]    r_m1;
  logic [SUM_W-1:0] sum;
  logic             live;
  logic             l_odd;
  logic             r_odd;

  assign {q_kind, q_lo, q_hi, q_val} = qdata;
  assign status.clearing = (state == ST_CLEAR);
  assign status.done     = done;

  always_comb begin
    par   = l >> 1;
    r_m1  = r - CW'(1);
    sum   = cur + rd0;
    live  = (l < r);
    l_odd = l[0] && live;
    r_odd = r[0] && live;
    pop   = (state == ST_IDLE) && !qempty;
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    ra0   = l[AW-1:0];
    ra1   = r_m1[AW-1:0];
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_SET: begin
        we = 1'b1;
        if (first) begin
          waddr = l[AW-1:0];
          wdata = cur;
          ra0   = l[AW-1:0] ^ AW'(1);
        end else begin
          waddr = par[AW-1:0];
          wdata = sum;
          ra0   = par[AW-1:0] ^ AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!qempty) begin
            l     <= q_lo;
            r     <= q_hi;
            cur   <= SUM_W'(q_val);
            acc   <= '0;
            first <= 1'b1;
            pend  <= 1'b0;
            case (q_kind)
              KIND_SET:   state <= ST_SET;
              KIND_QUERY: state <= ST_QUERY;
              default: begin
                done      <= 1'b1;
                range_sum <= '0;
              end
            endcase
          end
        end
        ST_SET: begin
          if (first) begin
            first <= 1'b0;
          end else begin
            cur <= sum;
            l   <= par;
            if (par == CW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_QUERY: begin
          // reads issued last cycle land now
          if (pend) begin
            acc <= acc + (v0 ? rd0 : '0) + (v1 ? rd1 : '0);
          end
          pend <= live;
          v0   <= l_odd;
          v1   <= r_odd;
          if (live) begin
            l <= (l + CW'(l_odd)) >> 1;
            r <= (r - CW'(r_odd)) >> 1;
          end else if (!pend) begin
            done      <= 1'b1;
            range_sum <= acc;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !done)
    else $error("result during clearing pass");

  a_empty_query_immediate: assert property (@(posedge clk) disable iff (rst)
    (pop && q_kind == KIND_EMPTY) |=> done)
    else $error("empty query gave no result");

  a_query_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUERY) |-> (l <= r))
    else $error("query walk crossed bounds");

  a_set_not_node_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET && we) |-> (waddr != '0))
    else $error("set walk wrote node zero");

endmodule

>>> design/segment_tree_range_sum.sv
// Top level of the segment tree range-sum block: config register, front end,
// item queue and tree walker. Uses stree_pkg, stree_front, stree_fifo, stree_back.
//
// After reset the node store (2*MAX_ELEMENTS entries) is cleared one entry a
// cycle; busy stays high until that pass is done. The walker visits one tree
// level per cycle through the single write port and two read ports of the
// node memory; an empty query is answered without a walk. Sets below
// size_in_use and all queries go through a two-entry queue; busy rises only
// while clearing or when that queue is full. A query's result is shown on
// range_sum for one cycle with done high and cannot be held off. Sets give
// no result.
module segment_tree_range_sum import stree_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode,
  input  logic [IDX_W-1:0]        index_or_left,
  input  logic [IDX_W-1:0]        right_end,
  input  logic signed [VAL_W-1:0] new_value,
  output logic                    done,
  output logic signed [SUM_W-1:0] range_sum,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int AW = $clog2(2 * MAX_ELEMENTS);
  localparam int CW = AW + 1;
  localparam int SW = $clog2(MAX_ELEMENTS + 1);
  localparam int W  = 2 + 2 * CW + VAL_W;
  localparam int KW = (SW > CFG_W) ? SW : CFG_W;

  logic [SW-1:0]  size_in_use;
  logic [KW-1:0]  wr_val;
  logic           push;
  logic [W-1:0]   fdata;
  logic [W-1:0]   qdata;
  logic           full;
  logic           qempty;
  logic           pop;
  back_status_t   status;

  assign pready = 1'b1;
  assign busy   = full || status.clearing;
  assign done   = status.done;
  assign wr_val = KW'(pwdata[CFG_W-1:0]);
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SW'(MAX_ELEMENTS);
    end else if (psel && penable && pwrite && paddr[2] == REG_SIZE_IN_USE) begin
      if (wr_val == '0) begin
        size_in_use <= SW'(1);
      end else if (wr_val > KW'(MAX_ELEMENTS)) begin
        size_in_use <= SW'(MAX_ELEMENTS);
      end else begin
        size_in_use <= wr_val[SW-1:0];
      end
    end
  end

  stree_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS), .SW(SW), .CW(CW), .W(W)
  ) u_front (
    .start(start), .busy(busy), .opcode(opcode),
    .index_or_left(index_or_left), .right_end(right_end),
    .new_value(new_value), .size_in_use(size_in_use),
    .push(push), .wdata(fdata)
  );

  stree_fifo #(.W(W)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(fdata), .pop(pop),
    .rdata(qdata), .full(full), .empty(qempty)
  );

  stree_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS), .AW(AW), .CW(CW), .W(W)
  ) u_back (
    .clk(clk), .rst(rst), .qdata(qdata), .qempty(qempty), .pop(pop),
    .status(status), .range_sum(range_sum)
  );

endmodule

>>> bench/tb.sv
// Testbench for segment_tree_range_sum: random and directed sets and range
// queries, checked against a behavioral sum over the elements. Depends on stree_pkg and the RTL.
module tb;
  import stree_pkg::*;

  localparam int N_ELEM = 1024;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 40;

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [VAL_W-1:0] v;
    bit               is_cfg;
    logic [31:0]      cfg_val;
    bit               drain;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = 1'b0;
  logic [IDX_W-1:0] index_or_left = '0;
  logic [IDX_W-1:0] right_end = '0;
  logic signed [VAL_W-1:0] new_value = '0;
  logic done;
  logic signed [SUM_W-1:0] range_sum;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  segment_tree_range_sum dut (.*);

  always #5 clk = ~clk;

  // behavioral copy of the array; sums computed directly over elements
  longint elems[N_ELEM];
  int unsigned live_size;
  logic [SUM_W-1:0] sums_due[$];
  item_t pending[$];
  int errors = 0;
  int idle_cycles = 0;
  bit feeding_done = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  task automatic queue_item(input item_t it);
    pending.insert(pending.size(), it);
  endtask

  function automatic void predict_item(input item_t it);
    longint s;
    int unsigned hi;
    s = 0;
    if (it.op == OP_SET) begin
      if (it.a < live_size) elems[it.a] = longint'($signed(it.v));
    end else begin
      hi = (it.b > live_size - 1) ? live_size - 1 : it.b;
      if (it.a < live_size && it.a <= hi)
        for (int i = it.a; i <= hi; i++) s += elems[i];
      sums_due.insert(sums_due.size(), s[SUM_W-1:0]);
    end
  endfunction

  function automatic item_t mk(input logic op, input int a, input int b, input logic [31:0] v);
    item_t it;
    it = '{op: op, a: a[IDX_W-1:0], b: b[IDX_W-1:0], v: v, is_cfg: 0, cfg_val: 0, drain: 0};
    return it;
  endfunction

  function automatic item_t mk_cfg(input logic [31:0] val);
    item_t it;
    it = mk(OP_SET, 0, 0, 0);
    it.is_cfg = 1;
    it.cfg_val = val;
    return it;
  endfunction

  function automatic item_t mk_drain();
    item_t it;
    it = mk(OP_SET, 0, 0, 0);
    it.drain = 1;
    return it;
  endfunction

  // driver: bursts with gaps; config writes and drains wait for idle
  int gap = 0, burst = 0, hold = 0;
  int cfg_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        start <= 1'b0;
      end else if (start) begin
      end else if (cfg_phase == 1) begin
        penable <= 1'b1;
        cfg_phase <= 2;
      end else if (cfg_phase == 2) begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_phase <= 0;
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending.size() > 0) begin
        if (pending[0].is_cfg || pending[0].drain) begin
          if (sums_due.size() == 0 && !busy) begin
            if (hold < SETTLE) hold <= hold + 1;
            else begin
              hold <= 0;
              if (pending[0].is_cfg) begin
                psel <= 1'b1;
                pwrite <= 1'b1;
                paddr <= {REG_SIZE_IN_USE, 2'b00};
                pwdata <= pending[0].cfg_val;
                live_size <= (pending[0].cfg_val[10:0] == 0) ? 1 :
                             (pending[0].cfg_val[10:0] > N_ELEM) ? N_ELEM :
                             pending[0].cfg_val[10:0];
                cfg_phase <= 1;
              end
              void'(pending.pop_front());
            end
          end
        end else begin
          opcode <= pending[0].op;
          index_or_left <= pending[0].a;
          right_end <= pending[0].b;
          new_value <= pending[0].v;
          start <= 1'b1;
          predict_item(pending.pop_front());
          if (burst > 0) burst <= burst - 1;
          else begin
            burst <= $urandom_range(0, 12);
            gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sums_due.size() == 0) report_mismatch("result with nothing expected");
      else begin
        if (range_sum !== sums_due[0])
          report_mismatch($sformatf("range_sum got %0d want %0d",
                                    range_sum, $signed(sums_due[0])));
        void'(sums_due.pop_front());
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_phase != 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic item_t rand_item(input int sz);
    int a, b;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h7fffffff;
      1: v = 32'h80000000;
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 9) < 5) begin
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, sz - 1);
      return mk(OP_SET, a, $urandom_range(0, 1023), v);
    end
    a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, sz - 1);
    b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(a, 1023);
    return mk(OP_QUERY, a, b, v);
  endfunction

  initial begin
    int sizes[6] = '{1024, 1, 0, 2047, 37, 300};
    for (int i = 0; i < N_ELEM; i++) elems[i] = 0;
    live_size = N_ELEM;
    // directed part at reset size
    queue_item(mk(OP_QUERY, 0, 1023, 0));
    queue_item(mk(OP_SET, 0, 0, 32'h7fffffff));
    queue_item(mk(OP_SET, 1023, 5, 32'h80000000));
    queue_item(mk(OP_SET, 512, 0, 32'hffffffff));
    queue_item(mk(OP_QUERY, 0, 1023, 32'hffffffff));
    queue_item(mk(OP_QUERY, 1023, 1023, 0));
    queue_item(mk(OP_QUERY, 600, 10, 0));
    queue_item(mk(OP_QUERY, 0, 0, 0));
    for (int i = 0; i < 8; i++) queue_item(mk(OP_SET, 1000 + i, 0, 32'h7fffffff));
    queue_item(mk(OP_QUERY, 1000, 1007, 0));
    queue_item(mk_drain());
    queue_item(mk_cfg(10));
    queue_item(mk(OP_SET, 10, 0, 32'h5));
    queue_item(mk(OP_SET, 9, 0, 32'h55555555));
    queue_item(mk(OP_QUERY, 0, 1023, 0));
    queue_item(mk(OP_QUERY, 10, 1023, 0));
    queue_item(mk(OP_QUERY, 3, 2, 0));
    // random phases over several sizes, extremes included
    for (int p = 0; p < 6; p++) begin
      int sz;
      sz = (sizes[p] == 0) ? 1 : (sizes[p] > N_ELEM ? N_ELEM : sizes[p]);
      queue_item(mk_cfg(sizes[p]));
      for (int k = 0; k < 75; k++) queue_item(rand_item(sz));
      queue_item(mk_drain());
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !start);
    wait (sums_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> sim.f
design/stree_pkg.sv
design/stree_fifo.sv
design/stree_front.sv
design/stree_back.sv
design/segment_tree_range_sum.sv
bench/tb.sv
